// File: rtl/fst_pkg.sv
// Shared types, codes and constants of the Fibonacci search table.
`default_nettype none

package fst_pkg;

	// Request payload widths
	localparam int ADDR_W     = 7;
	localparam int KEY_W      = 64;
	localparam int GROUP_W    = 16;
	localparam int TAG_W      = 7;
	localparam int POS_W      = 7;

	// Configuration port
	localparam int FIELD_W    = 2;
	localparam int LEN_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_FIELD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'b1;

	// Request operations
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Key selector codes
	localparam logic [FIELD_W-1:0] FIELD_ID    = 2'd0;
	localparam logic [FIELD_W-1:0] FIELD_NAME  = 2'd1;
	localparam logic [FIELD_W-1:0] FIELD_GROUP = 2'd2;

	// Fibonacci numbers; the 8-bit length never needs more than F(14) = 377
	localparam int FIB_W     = 9;
	localparam int FIB_MAX_K = 14;
	localparam logic [FIB_W-1:0] FIB_LUT [0:FIB_MAX_K] = '{
		9'd0, 9'd1, 9'd1, 9'd2, 9'd3, 9'd5, 9'd8, 9'd13, 9'd21,
		9'd34, 9'd55, 9'd89, 9'd144, 9'd233, 9'd377
	};

	// Probe sum: offset (8 bits) plus f2 (9 bits), minus one
	localparam int PROBE_W = 10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_FINAL,
		ST_FCMP,
		ST_DONE
	} fst_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_wr;
		logic start;
		logic rd_probe;
		logic step;
		logic rd_final;
		logic chk_final;
		logic out_load;
	} fst_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic trivial;
		logic eq;
		logic nx_probe;
		logic nx_final;
	} fst_sts_t;

endpackage

`default_nettype wire

// File: rtl/fst_req_if.sv
// Request channel: load or search request with its payload.
`default_nettype none

interface fst_req_if;
	import fst_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic [ADDR_W-1:0]  entry_address;
	logic [KEY_W-1:0]   id_key;
	logic [KEY_W-1:0]   name_key;
	logic [GROUP_W-1:0] group_number;
	logic [TAG_W-1:0]   record_tag;
	logic [KEY_W-1:0]   query_key;

	modport source (
		output valid, operation, entry_address, id_key, name_key, group_number,
		       record_tag, query_key,
		input  ready
	);

	modport sink (
		input  valid, operation, entry_address, id_key, name_key, group_number,
		       record_tag, query_key,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/fst_rsp_if.sv
// Response channel: search outcome.
`default_nettype none

interface fst_rsp_if;
	import fst_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [TAG_W-1:0] match_tag;
	logic [POS_W-1:0] match_position;

	modport source (
		output valid, found, match_tag, match_position,
		input  ready
	);

	modport sink (
		input  valid, found, match_tag, match_position,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/fst_ctrl.sv
// Search sequencer: request intake, probe/compare loop, response register valid.
`default_nettype none

module fst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_operation,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output fst_pkg::fst_cmd_t cmd,
	input  fst_pkg::fst_sts_t sts
);
	import fst_pkg::*;

	fst_state_t state_q;
	fst_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || rsp_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && req_operation == OP_SEARCH) begin
					if (sts.trivial)
						state_d = ST_DONE;
					else if (sts.nx_probe)
						state_d = ST_PROBE;
					else if (sts.nx_final)
						state_d = ST_FINAL;
					else
						state_d = ST_DONE;
				end
			end
			ST_PROBE: state_d = ST_CMP;
			ST_CMP: begin
				if (sts.eq)
					state_d = ST_DONE;
				else if (sts.nx_probe)
					state_d = ST_PROBE;
				else if (sts.nx_final)
					state_d = ST_FINAL;
				else
					state_d = ST_DONE;
			end
			ST_FINAL: state_d = ST_FCMP;
			ST_FCMP:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands and handshake
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.load_wr   = req_valid && req_operation == OP_LOAD;
				cmd.start     = req_valid && req_operation == OP_SEARCH;
			end
			ST_PROBE: cmd.rd_probe  = 1'b1;
			ST_CMP:   cmd.step      = 1'b1;
			ST_FINAL: cmd.rd_final  = 1'b1;
			ST_FCMP:  cmd.chk_final = 1'b1;
			ST_DONE:  cmd.out_load  = out_free;
			default: ;
		endcase
	end

	// Response register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/fst_datapath.sv
// Table memories, config registers, Fibonacci step unit, key compare, response regs.
`default_nettype none

module fst_datapath #(
	parameter int TABLE_DEPTH = 128,
	parameter int KEY_BITS    = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fst_pkg::fst_cmd_t                  cmd,
	output fst_pkg::fst_sts_t                  sts,
	input  logic                               cfg_we,
	input  logic [fst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [fst_pkg::ADDR_W-1:0]         entry_address,
	input  logic [fst_pkg::KEY_W-1:0]          id_key,
	input  logic [fst_pkg::KEY_W-1:0]          name_key,
	input  logic [fst_pkg::GROUP_W-1:0]        group_number,
	input  logic [fst_pkg::TAG_W-1:0]          record_tag,
	input  logic [fst_pkg::KEY_W-1:0]          query_key,
	output logic                               found,
	output logic [fst_pkg::TAG_W-1:0]          match_tag,
	output logic [fst_pkg::POS_W-1:0]          match_position
);
	import fst_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = (KEY_BITS > GROUP_W) ? KEY_BITS : GROUP_W;

	// Table storage
	logic [KEY_BITS-1:0] id_mem    [TABLE_DEPTH];
	logic [KEY_BITS-1:0] name_mem  [TABLE_DEPTH];
	logic [GROUP_W-1:0]  group_mem [TABLE_DEPTH];
	logic [TAG_W-1:0]    tag_mem   [TABLE_DEPTH];

	logic [KEY_BITS-1:0] rd_id_q;
	logic [KEY_BITS-1:0] rd_name_q;
	logic [GROUP_W-1:0]  rd_group_q;
	logic [TAG_W-1:0]    rd_tag_q;

	logic [FIELD_W-1:0]  field_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    len_n;
	logic [LEN_W-1:0]    last_pos;

	logic [FIB_W-1:0]    f_q, f1_q, f2_q;
	logic [FIB_W-1:0]    nx_f, nx_f1, nx_f2;
	logic [FIB_W-1:0]    init_f, init_f1, init_f2;
	logic [FIB_W-1:0]    f1m;
	logic [LEN_W-1:0]    op1_q;
	logic [LEN_W-1:0]    nx_op1;
	logic [PROBE_W-1:0]  probe_sum;
	logic [LEN_W-1:0]    probe_pos;
	logic [LEN_W-1:0]    pos_q;
	logic [CW-1:0]       query_q;

	logic                wr_ok;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [CW-1:0]       cmp_a, cmp_b;
	logic                cmp_lt, cmp_eq;

	logic                hit_q;
	logic [TAG_W-1:0]    tag_q;
	logic                found_q;
	logic [TAG_W-1:0]    mtag_q;
	logic [POS_W-1:0]    mpos_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= FIELD_ID;
			len_q   <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEARCH_FIELD: field_q <= cfg_wdata[FIELD_W-1:0];
				REG_TABLE_LENGTH: len_q   <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective length saturates at the table depth
	assign len_n    = (32'(len_q) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH) : len_q;
	assign last_pos = len_n - LEN_W'(1);

	// Smallest Fibonacci number not below the length, with its two predecessors
	always_comb begin
		init_f  = FIB_LUT[FIB_MAX_K];
		init_f1 = FIB_LUT[FIB_MAX_K-1];
		init_f2 = FIB_LUT[FIB_MAX_K-2];
		for (int k = FIB_MAX_K; k >= 2; k--) begin
			if (FIB_LUT[k] >= FIB_W'(len_n)) begin
				init_f  = FIB_LUT[k];
				init_f1 = FIB_LUT[k-1];
				init_f2 = FIB_LUT[k-2];
			end
		end
	end

	// Probe position: offset + f2 - 1, clipped to the last entry
	assign probe_sum = PROBE_W'(op1_q) + PROBE_W'(f2_q) - PROBE_W'(1);
	assign probe_pos = (probe_sum < PROBE_W'(last_pos)) ? LEN_W'(probe_sum) : last_pos;

	// Memory write and registered read
	assign wr_ok   = 32'(entry_address) < TABLE_DEPTH;
	assign rd_en   = cmd.rd_probe || cmd.rd_final;
	assign rd_addr = cmd.rd_final ? AW'(op1_q) : AW'(probe_pos);

	always_ff @(posedge clk) begin
		if (cmd.load_wr && wr_ok) begin
			id_mem[AW'(entry_address)]    <= id_key[KEY_BITS-1:0];
			name_mem[AW'(entry_address)]  <= name_key[KEY_BITS-1:0];
			group_mem[AW'(entry_address)] <= group_number;
			tag_mem[AW'(entry_address)]   <= record_tag;
		end
		if (rd_en) begin
			rd_id_q    <= id_mem[rd_addr];
			rd_name_q  <= name_mem[rd_addr];
			rd_group_q <= group_mem[rd_addr];
			rd_tag_q   <= tag_mem[rd_addr];
		end
	end

	// Key select and compare
	always_comb begin
		case (field_q)
			FIELD_ID: begin
				cmp_a = CW'(rd_id_q);
				cmp_b = CW'(query_q[KEY_BITS-1:0]);
			end
			FIELD_NAME: begin
				cmp_a = CW'(rd_name_q);
				cmp_b = CW'(query_q[KEY_BITS-1:0]);
			end
			FIELD_GROUP: begin
				cmp_a = CW'(rd_group_q);
				cmp_b = CW'(query_q[GROUP_W-1:0]);
			end
			default: begin
				cmp_a = CW'(rd_id_q);
				cmp_b = CW'(query_q[KEY_BITS-1:0]);
			end
		endcase
	end

	assign cmp_lt = cmp_a < cmp_b;
	assign cmp_eq = cmp_a == cmp_b;

	// Fibonacci step: shrink by one (key above entry) or two (key below entry)
	assign f1m = f1_q - f2_q;

	always_comb begin
		nx_f   = f_q;
		nx_f1  = f1_q;
		nx_f2  = f2_q;
		nx_op1 = op1_q;
		if (cmd.start) begin
			nx_f   = init_f;
			nx_f1  = init_f1;
			nx_f2  = init_f2;
			nx_op1 = '0;
		end else if (cmd.step) begin
			if (cmp_lt) begin
				nx_f   = f1_q;
				nx_f1  = f2_q;
				nx_f2  = f1m;
				nx_op1 = pos_q + LEN_W'(1);
			end else if (!cmp_eq) begin
				nx_f   = f2_q;
				nx_f1  = f1m;
				nx_f2  = f2_q - f1m;
			end
		end
	end

	always_ff @(posedge clk) begin
		f_q   <= nx_f;
		f1_q  <= nx_f1;
		f2_q  <= nx_f2;
		op1_q <= nx_op1;
		if (cmd.start)
			query_q <= query_key[CW-1:0];
		if (cmd.rd_probe)
			pos_q <= probe_pos;
		else if (cmd.rd_final)
			pos_q <= op1_q;
	end

	// Status toward the sequencer
	always_comb begin
		sts.trivial  = !(field_q inside {FIELD_ID, FIELD_NAME, FIELD_GROUP}) ||
		               len_n == '0;
		sts.eq       = cmp_eq;
		sts.nx_probe = nx_f > FIB_W'(1);
		sts.nx_final = (nx_f1 != '0) && (nx_op1 < len_n);
	end

	// Match capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q <= 1'b0;
		end else if ((cmd.step || cmd.chk_final) && cmp_eq) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.step || cmd.chk_final) && cmp_eq)
			tag_q <= rd_tag_q;
	end

	// Response register; a miss reads all zero
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_q <= hit_q;
			mtag_q  <= hit_q ? tag_q : '0;
			mpos_q  <= hit_q ? POS_W'(pos_q) : '0;
		end
	end

	assign found          = found_q;
	assign match_tag      = mtag_q;
	assign match_position = mpos_q;

endmodule

`default_nettype wire

// File: rtl/fibonacci_search_table.sv
// Top level of the Fibonacci search table: sequencer, datapath and checks.
`default_nettype none

// A table of TABLE_DEPTH records (id key, name key, group number, tag) that is searched
// by Fibonacci search over the first table_length entries, on the key chosen by
// search_field; the entries must be loaded in ascending order of that key. A load
// request writes one entry and returns nothing. A search request returns one
// response: found, the stored tag and the position of the match, zeros on a miss.
// Searches run one at a time: each probe is a registered table read followed by a
// compare, and a search holds the request channel until its response is loaded
// into the output register. A search takes about 11 probes for 128 entries,
// counting the closing single-entry check, fewer for a shorter table. An unused
// selector or a zero length answers a miss without reading the table. A finished
// response waits in an output register, and loads are still taken while it waits.
module fibonacci_search_table #(
	parameter int TABLE_DEPTH = 128,
	parameter int KEY_BITS    = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fst_req_if.sink                        req,
	fst_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [fst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fst_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fst_pkg::*;

	fst_cmd_t cmd;
	fst_sts_t sts;

	fst_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.req_ready     (req.ready),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.cmd           (cmd),
		.sts           (sts)
	);

	fst_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.entry_address  (req.entry_address),
		.id_key         (req.id_key),
		.name_key       (req.name_key),
		.group_number   (req.group_number),
		.record_tag     (req.record_tag),
		.query_key      (req.query_key),
		.found          (rsp.found),
		.match_tag      (rsp.match_tag),
		.match_position (rsp.match_position)
	);

	// A miss carries zero tag and position
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.match_tag == '0 && rsp.match_position == '0)
		else $error("miss response with nonzero tag or position");

	// A load never creates a response
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.operation == OP_LOAD && !rsp.valid |=> !rsp.valid)
		else $error("response appeared after a load request");

	// A search holds off the next request
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.operation == OP_SEARCH |=> !req.ready)
		else $error("request taken while a search is running");

endmodule

`default_nettype wire
